### sv/dpmc_pkg.sv
// Shared types, widths, register indexes and the control store of the dual PI motor controller.
package dpmc_pkg;

  // Field and datapath widths
  localparam int GW       = 16;          // gains, scale factors, unit operand b
  localparam int MW       = 54;          // magnitude width inside the multiply/divide unit
  localparam int DW       = MW + 1;      // signed operand/result width of the unit
  localparam int TW       = 37;          // scaled setpoint
  localparam int EW       = 38;          // control error
  localparam int SATW     = EW + 1;      // integral + error before saturation
  localparam int SW       = 44;          // proportional term and PI sum
  localparam int SPW      = 21;          // setpoint field
  localparam int MEASW    = 32;          // measured field
  localparam int IW       = 32;          // integrals and last position error
  localparam int DRW      = 16;          // drive field
  localparam int WLW      = 24;          // windup limit register
  localparam int DLW      = 15;          // position drive limit register

  localparam int MUL_STEPS = GW;         // one multiplier bit per cycle
  localparam int DIV_STEPS = MW / 2;     // two quotient bits per cycle
  localparam int CNTW      = $clog2(DIV_STEPS);

  localparam logic [GW-1:0]         MILLE      = GW'(1000);
  localparam logic signed [DRW-1:0] VEL_HI     = 16'sd100;
  localparam logic signed [DRW-1:0] VEL_LO     = -16'sd100;
  localparam int                    IN_POS_TOL = 10;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 24;

  localparam logic [CFG_AW-1:0] R_SCALE_NUM  = 3'd0;
  localparam logic [CFG_AW-1:0] R_SCALE_DEN  = 3'd1;
  localparam logic [CFG_AW-1:0] R_VEL_P      = 3'd2;
  localparam logic [CFG_AW-1:0] R_VEL_I      = 3'd3;
  localparam logic [CFG_AW-1:0] R_POS_P      = 3'd4;
  localparam logic [CFG_AW-1:0] R_POS_I      = 3'd5;
  localparam logic [CFG_AW-1:0] R_POS_WINDUP = 3'd6;
  localparam logic [CFG_AW-1:0] R_POS_DRIVE  = 3'd7;

  // Item kinds
  localparam logic [1:0] K_VEL   = 2'd0;
  localparam logic [1:0] K_POS   = 2'd1;
  localparam logic [1:0] K_CLEAR = 2'd2;

  // Multiply/divide unit request
  typedef enum logic {MD_MUL, MD_DIV} md_op_t;

  typedef struct packed {
    logic   start;
    md_op_t op;
  } md_req_t;

  // Micro-operations
  typedef enum logic [3:0] {
    U_NONE, U_FETCH, U_MUL_SCALE, U_DIV_SCALE, U_ERR, U_MUL_PROP, U_DIV_MILLE,
    U_INTEG, U_MUL_INTEG, U_SUM, U_LIMIT, U_MISC, U_EMIT
  } uop_t;

  // Sequencing conditions
  typedef enum logic [2:0] {
    C_NEXT,       // step on
    C_JUMP,       // go to target
    C_WAIT_ITEM,  // hold until an item is taken
    C_WAIT_UNIT,  // hold while the multiply/divide unit runs
    C_WAIT_OUT,   // hold until the result register is free, then go to target
    C_KIND_MISC   // clear or unused kind: go to target
  } cond_t;

  localparam int PROG_LEN = 20;
  localparam int PCW      = $clog2(PROG_LEN);

  typedef struct packed {
    uop_t            op;
    cond_t           cnd;
    logic [PCW-1:0]  tgt;
  } ctrl_t;

  localparam logic [PCW-1:0] A_FETCH = PCW'(0);
  localparam logic [PCW-1:0] A_MISC  = PCW'(18);
  localparam logic [PCW-1:0] A_EMIT  = PCW'(19);

  localparam ctrl_t UCODE [PROG_LEN] = '{
    '{U_FETCH,     C_WAIT_ITEM, A_FETCH},  // 0
    '{U_NONE,      C_KIND_MISC, A_MISC},   // 1
    '{U_MUL_SCALE, C_NEXT,      A_FETCH},  // 2  setpoint * numerator
    '{U_NONE,      C_WAIT_UNIT, A_FETCH},  // 3
    '{U_DIV_SCALE, C_NEXT,      A_FETCH},  // 4  / denominator
    '{U_NONE,      C_WAIT_UNIT, A_FETCH},  // 5
    '{U_ERR,       C_NEXT,      A_FETCH},  // 6  error, at-rest flag
    '{U_MUL_PROP,  C_NEXT,      A_FETCH},  // 7  P * error
    '{U_NONE,      C_WAIT_UNIT, A_FETCH},  // 8
    '{U_DIV_MILLE, C_NEXT,      A_FETCH},  // 9  / 1000
    '{U_NONE,      C_WAIT_UNIT, A_FETCH},  // 10
    '{U_INTEG,     C_NEXT,      A_FETCH},  // 11 integral update
    '{U_MUL_INTEG, C_NEXT,      A_FETCH},  // 12 I * integral
    '{U_NONE,      C_WAIT_UNIT, A_FETCH},  // 13
    '{U_DIV_MILLE, C_NEXT,      A_FETCH},  // 14 / 1000
    '{U_NONE,      C_WAIT_UNIT, A_FETCH},  // 15
    '{U_SUM,       C_NEXT,      A_FETCH},  // 16
    '{U_LIMIT,     C_JUMP,      A_EMIT},   // 17
    '{U_MISC,      C_NEXT,      A_FETCH},  // 18 clear or unused kind
    '{U_EMIT,      C_WAIT_OUT,  A_FETCH}   // 19
  };

  // Saturate to the 32-bit signed range
  function automatic logic signed [IW-1:0] sat32(input logic signed [SATW-1:0] v);
    logic [SATW-IW:0] top;
    top = v[SATW-1:IW-1];
    if (top == '0 || top == '1) begin
      return v[IW-1:0];
    end
    return v[SATW-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
  endfunction

endpackage

### sv/dpmc_muldiv.sv
// Shared sign-magnitude multiply (one bit a cycle) and divide (two bits a cycle) unit.
module dpmc_muldiv (
  input  logic                                clk,
  input  logic                                rst,
  input  dpmc_pkg::md_req_t                   req,
  input  logic signed [dpmc_pkg::DW-1:0]      a,
  input  logic        [dpmc_pkg::GW-1:0]      b,
  output logic                                busy,
  output logic signed [dpmc_pkg::DW-1:0]      result
);
  import dpmc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIX  = 4'b1000
  } state_t;

  state_t          state, state_next;
  logic            neg;
  logic            is_mul;
  logic [MW-1:0]   work;     // multiplicand, or dividend shifting into quotient
  logic [MW-1:0]   acc;      // product
  logic [GW-1:0]   opnd;     // multiplier bits or divisor
  logic [GW-1:0]   rem;
  logic [CNTW-1:0] cnt;

  logic [DW-1:0]   a_mag;
  logic [GW:0]     r1s, r2s;
  logic            ge1, ge2;
  logic [GW-1:0]   r1, r2;
  logic [MW-1:0]   acc_next;
  logic [MW-1:0]   fin;

  assign a_mag    = a[DW-1] ? -a : a;
  assign acc_next = {acc[MW-2:0], 1'b0} + (opnd[GW-1] ? work : '0);

  // two restoring steps
  always_comb begin
    r1s = {rem, work[MW-1]};
    ge1 = r1s >= {1'b0, opnd};
    r1  = ge1 ? GW'(r1s - {1'b0, opnd}) : r1s[GW-1:0];
    r2s = {r1, work[MW-2]};
    ge2 = r2s >= {1'b0, opnd};
    r2  = ge2 ? GW'(r2s - {1'b0, opnd}) : r2s[GW-1:0];
  end

  assign fin  = is_mul ? acc : work;
  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req.start) state_next = (req.op == MD_MUL) ? S_MUL : S_DIV;
      S_MUL:   if (cnt == CNTW'(MUL_STEPS - 1)) state_next = S_FIX;
      S_DIV:   if (cnt == CNTW'(DIV_STEPS - 1)) state_next = S_FIX;
      S_FIX:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req.start) begin
          neg    <= a[DW-1];
          is_mul <= (req.op == MD_MUL);
          work   <= a_mag[MW-1:0];
          opnd   <= b;
          acc    <= '0;
          rem    <= '0;
          cnt    <= '0;
        end
      end
      S_MUL: begin
        acc  <= acc_next;
        opnd <= {opnd[GW-2:0], 1'b0};
        cnt  <= cnt + 1'b1;
      end
      S_DIV: begin
        work <= {work[MW-3:0], ge1, ge2};
        rem  <= r2;
        cnt  <= cnt + 1'b1;
      end
      S_FIX: begin
        result <= neg ? -$signed({1'b0, fin}) : $signed({1'b0, fin});
      end
      default: ;
    endcase
  end

endmodule

### sv/dual_pi_motor_controller_top.sv
// Top level of the dual PI motor controller: microcoded sequencer, datapath and ports.
//
//  channel   direction  handshake         payload
//  s_*       in         tvalid / tready   tdata: setpoint, measured   tuser: kind
//  m_*       out        tvalid / tready   tdata: drive, in_position  tuser: drive_valid
//  cfg_*     in         cfg_we only       cfg_addr selects register, cfg_data value
//
// A velocity or position item runs from acceptance to its result being loaded
// through three multiplies (one multiplier bit a cycle in the shared unit) and
// three divides (two quotient bits a cycle), plus seven other control words,
// the fetch step included. Clear and unused kinds pass through only the fetch,
// kind test, clear and emit steps.
// One item is in work at a time; a stalled result sits in the output register
// while the next item is taken and worked on, and the sequencer waits at its
// last step only if that register is still full. Reset is synchronous and
// returns the registers to their defaults and clears both integrals.
module dual_pi_motor_controller_top (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic [dpmc_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [dpmc_pkg::CFG_DW-1:0]     cfg_data,
  // input items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [55:0]                     s_tdata,   // [20:0] setpoint, [52:21] measured
  input  logic [1:0]                      s_tuser,   // [1:0] kind
  // result items
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,   // [15:0] drive, [16] in_position
  output logic                            m_tuser    // [0] drive_valid
);
  import dpmc_pkg::*;

  // configuration registers
  logic [GW-1:0]  scale_num, scale_den, vel_p, vel_i, pos_p, pos_i;
  logic [WLW-1:0] windup_lim;
  logic [DLW-1:0] drive_lim;

  // sequencer
  logic [PCW-1:0] pc, pc_next, pc_inc;
  ctrl_t          cw;
  logic           in_fire, out_load;

  // item registers
  logic [1:0]                kind_r;
  logic signed [SPW-1:0]     sp_r;
  logic signed [MEASW-1:0]   meas_r;

  // working registers
  logic signed [EW-1:0]  err;
  logic                  rest;
  logic signed [SW-1:0]  pterm, sum;
  logic signed [IW-1:0]  cand;
  logic signed [DRW-1:0] drive_r;
  logic                  dvalid;

  // state
  logic signed [IW-1:0]  vint, pint, lpe;

  // unit
  md_req_t               md_req;
  logic signed [DW-1:0]  md_a, md_res;
  logic [GW-1:0]         md_b;
  logic                  md_busy;

  // datapath combinational
  logic signed [TW-1:0]   target;
  logic signed [IW-1:0]   base;
  logic signed [SATW-1:0] raw;
  logic signed [IW-1:0]   sat, clamped, wl_s;
  logic signed [SW-1:0]   dl_s;
  logic                   inpos;
  logic signed [IW-1:0]   tol_s;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_num  <= GW'(1);
      scale_den  <= GW'(1);
      vel_p      <= '0;
      vel_i      <= '0;
      pos_p      <= '0;
      pos_i      <= '0;
      windup_lim <= '0;
      drive_lim  <= DLW'(100);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        R_SCALE_NUM:  scale_num  <= cfg_data[GW-1:0];
        R_SCALE_DEN:  scale_den  <= cfg_data[GW-1:0];
        R_VEL_P:      vel_p      <= cfg_data[GW-1:0];
        R_VEL_I:      vel_i      <= cfg_data[GW-1:0];
        R_POS_P:      pos_p      <= cfg_data[GW-1:0];
        R_POS_I:      pos_i      <= cfg_data[GW-1:0];
        R_POS_WINDUP: windup_lim <= cfg_data[WLW-1:0];
        R_POS_DRIVE:  drive_lim  <= cfg_data[DLW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  assign cw       = UCODE[pc];
  assign pc_inc   = pc + 1'b1;
  assign s_tready = (cw.op == U_FETCH);
  assign in_fire  = s_tvalid && s_tready;
  assign out_load = (cw.op == U_EMIT) && (!m_tvalid || m_tready);

  always_comb begin
    pc_next = pc;
    unique case (cw.cnd)
      C_NEXT:      pc_next = pc_inc;
      C_JUMP:      pc_next = cw.tgt;
      C_WAIT_ITEM: pc_next = in_fire ? pc_inc : pc;
      C_WAIT_UNIT: pc_next = md_busy ? pc : pc_inc;
      C_WAIT_OUT:  pc_next = out_load ? cw.tgt : pc;
      C_KIND_MISC: pc_next = kind_r[1] ? cw.tgt : pc_inc;
      default:     pc_next = pc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= A_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

  // ---------------- multiply/divide requests ----------------
  always_comb begin
    md_req.start = 1'b0;
    md_req.op    = MD_MUL;
    md_a         = md_res;
    md_b         = MILLE;
    unique case (cw.op)
      U_MUL_SCALE: begin
        md_req = '{start: 1'b1, op: MD_MUL};
        md_a   = DW'(sp_r);
        md_b   = scale_num;
      end
      U_DIV_SCALE: begin
        md_req = '{start: 1'b1, op: MD_DIV};
        md_b   = (scale_den == '0) ? GW'(1) : scale_den;  // zero treated as one
      end
      U_MUL_PROP: begin
        md_req = '{start: 1'b1, op: MD_MUL};
        md_a   = DW'(err);
        md_b   = kind_r[0] ? pos_p : vel_p;
      end
      U_MUL_INTEG: begin
        md_req = '{start: 1'b1, op: MD_MUL};
        md_a   = DW'(cand);
        md_b   = kind_r[0] ? pos_i : vel_i;
      end
      U_DIV_MILLE: begin
        md_req = '{start: 1'b1, op: MD_DIV};
      end
      default: ;
    endcase
  end

  dpmc_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .req    (md_req),
    .a      (md_a),
    .b      (md_b),
    .busy   (md_busy),
    .result (md_res)
  );

  // ---------------- datapath ----------------
  assign target = md_res[TW-1:0];

  // integral update: velocity restarts from zero at rest, position shares the adder
  always_comb begin
    base    = kind_r[0] ? pint : (rest ? '0 : vint);
    raw     = SATW'(base) + SATW'(err);
    sat     = sat32(raw);
    wl_s    = $signed({{(IW-WLW){1'b0}}, windup_lim});
    clamped = (sat > wl_s) ? wl_s : ((sat < -wl_s) ? -wl_s : sat);
    dl_s    = $signed({{(SW-DLW){1'b0}}, drive_lim});
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= s_tuser;
      sp_r   <= s_tdata[SPW-1:0];
      meas_r <= s_tdata[SPW+MEASW-1:SPW];
    end
    unique case (cw.op)
      U_ERR: begin
        err  <= EW'(target) - EW'(meas_r);
        rest <= (target == '0) && (meas_r == '0);
      end
      U_INTEG: begin
        pterm <= md_res[SW-1:0];
        if (kind_r[0]) begin
          cand <= (err == '0) ? '0 : clamped;
        end else begin
          cand <= sat;
        end
      end
      U_SUM: sum <= pterm + md_res[SW-1:0];
      U_LIMIT: begin
        dvalid <= 1'b1;
        if (kind_r[0]) begin
          if (sum > dl_s) begin
            drive_r <= $signed({1'b0, drive_lim});
          end else if (sum < -dl_s) begin
            drive_r <= -$signed({1'b0, drive_lim});
          end else begin
            drive_r <= sum[DRW-1:0];
          end
        end else begin
          if (sum > SW'(VEL_HI)) begin
            drive_r <= VEL_HI;
          end else if (sum < SW'(VEL_LO)) begin
            drive_r <= VEL_LO;
          end else begin
            drive_r <= sum[DRW-1:0];
          end
        end
      end
      U_MISC: begin
        drive_r <= '0;
        dvalid  <= 1'b0;
      end
      default: ;
    endcase
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      vint <= '0;
      pint <= '0;
      lpe  <= '0;
    end else begin
      unique case (cw.op)
        U_INTEG: begin
          if (kind_r[0]) begin
            pint <= (err == '0) ? '0 : clamped;
            lpe  <= sat32(SATW'(err));
          end else if (rest) begin
            vint <= '0;
          end
        end
        U_LIMIT: begin
          // velocity integral moves only while the drive is not limited
          if (!kind_r[0] && sum <= SW'(VEL_HI) && sum >= SW'(VEL_LO)) begin
            vint <= cand;
          end
        end
        U_MISC: begin
          if (kind_r == K_CLEAR) begin
            vint <= '0;
            pint <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- result register ----------------
  assign tol_s = IW'(IN_POS_TOL);
  assign inpos = (lpe < tol_s) && (lpe > -tol_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'd0, inpos, drive_r};
      m_tuser <= dvalid;
    end
  end

  // ---------------- checks ----------------
  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !md_busy)
    else $error("item taken while the multiply/divide unit is running");

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    md_req.start |-> !md_busy)
    else $error("unit started while busy");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready)
    else $error("second item taken before the first was worked");

  a_vel_limit: assert property (@(posedge clk) disable iff (rst)
    (cw.op == U_LIMIT && kind_r == K_VEL) |=> (drive_r <= VEL_HI && drive_r >= VEL_LO))
    else $error("velocity drive out of range");

  a_windup: assert property (@(posedge clk) disable iff (rst)
    (cw.op == U_INTEG && kind_r == K_POS) |=> (pint <= wl_s && pint >= -wl_s))
    else $error("position integral beyond windup limit");

endmodule
